// ===== src/rldm_pkg.sv =====
// Shared constants and command/status types for the RMS level meter.
// No dependencies; imported by the controller, datapath and top level.
package rldm_pkg;

  localparam int SampleW   = 16;
  localparam int SumW      = 46;
  localparam int CountW    = 17;
  localparam int LevelW    = 17;
  localparam int LogFrac   = 24;
  localparam int ExpW      = 6;
  localparam int LgW       = ExpW + LogFrac;
  localparam int MantW     = 32;
  localparam int IterW     = 5;

  localparam logic [CountW-1:0] MaxBlockLen = CountW'(65536);
  localparam logic [SumW-1:0]   SumMax      = {SumW{1'b1}};

  // 10*log10(2) in Q.24, split into two 13-bit halves for the multiplier
  localparam int DbPerOct    = 50504453;
  localparam int ConstSplit  = 13;
  localparam logic [12:0] DbLo = 13'(DbPerOct % (1 << ConstSplit));
  localparam logic [12:0] DbHi = 13'(DbPerOct / (1 << ConstSplit));
  localparam logic signed [35:0] DbOffset = 36'sd50504453;
  localparam logic signed [31:0] LgBias   = 32'sd503316480;  // 30 in Q.24

  localparam logic signed [LevelW-1:0] FloorLevel = -17'sd51200;
  localparam logic signed [LevelW-1:0] CeilLevel  = 17'sd1024;

  localparam logic [IterW-1:0] LastIter = IterW'(LogFrac - 1);

  typedef struct packed {
    logic acc;        // accumulate the accepted sample
    logic load_norm;  // load normalizer
    logic norm_src;   // 0: square sum, 1: sample count
    logic norm_shift; // shift normalizer one place
    logic log_init;   // take mantissa from normalizer
    logic log_step;   // one squaring step
    logic save_lg;    // store log result, norm_src picks the slot
    logic mul_lo;
    logic mul_hi;
    logic db;
    logic lvl;
    logic out_load;   // load result register and clear block state
  } cmd_t;

  typedef struct packed {
    logic norm_top;
    logic sum_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== src/rldm_ctrl.sv =====
// Sequencer for the RMS level meter: accumulation, two log passes, scaling.
// Depends on rldm_pkg; drives rldm_dp through cmd_t and reads stat_t.
module rldm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  rldm_pkg::stat_t stat_i,
  output rldm_pkg::cmd_t  cmd_o
);
  import rldm_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SStart = 4'd1;
  localparam logic [3:0] SNorm  = 4'd2;
  localparam logic [3:0] SLog   = 4'd3;
  localparam logic [3:0] SSave  = 4'd4;
  localparam logic [3:0] SMulLo = 4'd5;
  localparam logic [3:0] SMulHi = 4'd6;
  localparam logic [3:0] SDb    = 4'd7;
  localparam logic [3:0] SLvl   = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;
  localparam logic [3:0] SCnt   = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             pass_q, pass_d;

  assign in_ready_o = (state_q == SIdle);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.norm_src = pass_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) state_d = SStart;
        end
      end
      SStart: begin
        if (stat_i.sum_zero) begin
          state_d = SOut;
        end else begin
          cmd_o.load_norm = 1'b1;
          cmd_o.norm_src  = 1'b0;
          pass_d  = 1'b0;
          state_d = SNorm;
        end
      end
      SNorm: begin
        if (stat_i.norm_top) begin
          cmd_o.log_init = 1'b1;
          iter_d  = '0;
          state_d = SLog;
        end else begin
          cmd_o.norm_shift = 1'b1;
        end
      end
      SLog: begin
        cmd_o.log_step = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) state_d = SSave;
      end
      SSave: begin
        cmd_o.save_lg = 1'b1;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = SCnt;
        end else begin
          state_d = SMulLo;
        end
      end
      // start the count pass with a fresh normalizer load
      SCnt: begin
        cmd_o.load_norm = 1'b1;
        cmd_o.norm_src  = 1'b1;
        state_d = SNorm;
      end
      SMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d = SMulHi;
      end
      SMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d = SDb;
      end
      SDb: begin
        cmd_o.db = 1'b1;
        state_d = SLvl;
      end
      SLvl: begin
        cmd_o.lvl = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      iter_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== src/rldm_dp.sv =====
// Datapath of the RMS level meter: accumulator, normalizer, log2 unit,
// dB scaling and result register. Depends on rldm_pkg; driven by rldm_ctrl.
module rldm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rldm_pkg::cmd_t                    cmd_i,
  output rldm_pkg::stat_t                   stat_o,
  input  logic signed [rldm_pkg::SampleW-1:0] sample_i,
  output logic signed [rldm_pkg::LevelW-1:0]  level_db_o,
  output logic                              silent_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i
);
  import rldm_pkg::*;

  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]   norm_q;
  logic [ExpW-1:0]   exp_q;
  logic [MantW-1:0]  mant_q;
  logic [LogFrac-1:0] frac_q;
  logic [LgW-1:0]    lga_q, lgb_q;
  logic [55:0]       prod_q;
  logic              neg_q;
  logic signed [35:0] d_q;
  logic signed [LevelW-1:0] lvl_q;
  logic signed [LevelW-1:0] level_q;
  logic              silent_q, valid_q;

  logic [31:0]       sq;
  logic [SumW:0]     sum_add;
  logic [63:0]       msq;
  logic [32:0]       mtop;
  logic signed [31:0] lg_diff;
  logic [29:0]       lmag;
  logic [12:0]       cmul;
  logic [42:0]       pp;
  logic [32:0]       rmag;
  logic signed [35:0] d_new;
  logic [35:0]       dmag;
  logic [19:0]       qmag;
  logic signed [20:0] lv;

  // Square and saturating accumulate
  assign sq      = 32'(sample_i * sample_i);
  assign sum_add = {1'b0, sum_q} + {15'd0, sq};
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.acc && cnt_q < MaxBlockLen) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    end
    if (cmd_i.out_load) begin
      sum_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Log2 step: square mantissa, take next fraction bit
  assign msq  = mant_q * mant_q;
  assign mtop = msq[63:31];

  // Scale log difference by 10*log10(2), two partial products
  assign lg_diff = $signed({2'b00, lga_q}) - $signed({2'b00, lgb_q}) - LgBias;
  assign lmag    = lg_diff[31] ? 30'(-lg_diff) : lg_diff[29:0];
  assign cmul    = cmd_i.mul_hi ? DbHi : DbLo;
  assign pp      = lmag * cmul;

  // Round the products to Q.24 and to 1/256 dB
  assign rmag  = 33'((prod_q + 56'(1 << (LogFrac - 1))) >> LogFrac);
  assign d_new = (neg_q ? -$signed({3'b000, rmag}) : $signed({3'b000, rmag})) + DbOffset;
  assign dmag  = d_q[35] ? 36'(-d_q) : d_q;
  assign qmag  = 20'((dmag + 36'd32768) >> 16);
  assign lv    = d_q[35] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_norm) begin
      norm_q <= cmd_i.norm_src ? {{(SumW-CountW){1'b0}}, cnt_q} : sum_q;
      exp_q  <= ExpW'(SumW - 1);
    end else if (cmd_i.norm_shift) begin
      norm_q <= {norm_q[SumW-2:0], 1'b0};
      exp_q  <= exp_q - 1'b1;
    end
    if (cmd_i.log_init) begin
      mant_q <= norm_q[SumW-1 -: MantW];
      frac_q <= '0;
    end else if (cmd_i.log_step) begin
      mant_q <= mtop[32] ? mtop[32:1] : mtop[31:0];
      frac_q <= {frac_q[LogFrac-2:0], mtop[32]};
    end
    if (cmd_i.save_lg) begin
      if (cmd_i.norm_src) lgb_q <= {exp_q, frac_q};
      else                lga_q <= {exp_q, frac_q};
    end
    if (cmd_i.mul_lo) begin
      prod_q <= {13'd0, pp};
      neg_q  <= lg_diff[31];
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + {pp, 13'd0};
    end
    if (cmd_i.db) d_q <= d_new;
    if (cmd_i.lvl) begin
      if (lv < 21'(FloorLevel))     lvl_q <= FloorLevel;
      else if (lv > 21'(CeilLevel)) lvl_q <= CeilLevel;
      else                          lvl_q <= lv[LevelW-1:0];
    end
    if (cmd_i.out_load) begin
      level_q  <= (sum_q == '0) ? FloorLevel : lvl_q;
      silent_q <= (sum_q == '0);
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign stat_o.norm_top = norm_q[SumW-1];
  assign stat_o.sum_zero = (sum_q == '0);
  assign stat_o.out_free = !valid_q || out_ready_i;

  assign level_db_o  = level_q;
  assign silent_o    = silent_q;
  assign out_valid_o = valid_q;

endmodule

// ===== src/rms_level_db_meter_top.sv =====
// Top level of the RMS level meter: stream ports, controller and datapath.
// Depends on rldm_pkg, rldm_ctrl and rldm_dp.
//
// Samples are accepted one per cycle while a block is being summed; each
// sample's square, up to 65536 samples per block, is added to a saturating
// 46-bit sum in the cycle it arrives. A sample with tlast closes the block:
// the input then stalls while one shared 32x32 squarer computes log2 of the
// sum and of the count (normalize, 24 squaring steps and a store for each),
// then two partial products, dB offset, clamp and output load; an all-zero
// block skips to the output load, which waits until the output is free.
// The result (level in 1/256 dB, -200 dB floor, plus a silence flag) sits in
// an output register, so the next block is taken while it waits.
module rms_level_db_meter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic        s_axis_tlast_i,   // last_sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [16:0] level_db, [23:17] zero
  output logic        m_axis_tuser_o    // [0] silent
);
  import rldm_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic signed [LevelW-1:0] level_db;

  rldm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rldm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_i    (s_axis_tdata_i),
    .level_db_o  (level_db),
    .silent_o    (m_axis_tuser_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'd0, level_db};

endmodule

// ===== tb/sv/rms_level_db_meter_top_tb.sv =====
// Self-checking testbench for rms_level_db_meter_top: block RMS level in dB.
// Depends on rldm_pkg and the RTL of the level meter; predicts every block
// result internally or from a typed row, and checks it against the master stream.
`timescale 1ns / 100ps

module rms_level_db_meter_top_tb;
  import rldm_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 300;

  typedef struct {
    logic signed [LevelW-1:0] level;
    logic                     silent;
  } level_t;

  typedef struct {
    logic [SampleW-1:0]       smp;
    logic                     lst;
    logic                     typed;
    logic signed [LevelW-1:0] level;
    logic                     silent;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  level_t      level_q[$];
  row_t        rows[19];
  int          err_cnt = 0;
  int          cyc_cnt = 0;
  bit          no_idle = 1'b0;

  // Block state of the predictor
  logic [SumW-1:0]   blk_sum = '0;
  logic [CountW-1:0] blk_cnt = '0;

  rms_level_db_meter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // log2 of a nonzero value in Q.24 by repeated squaring of the mantissa
  function automatic longint log2_q24(input logic [63:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 63;
    frac = '0;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 31) m = v >> (e - 31);
    else m = v << (31 - e);
    for (int i = 0; i < LogFrac; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return longint'((64'(e) << LogFrac) | frac);
  endfunction

  // divide by 2^n, nearest, ties away from zero
  function automatic longint round_pow2(input longint x, input int n);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (longint'(1) << (n - 1))) >>> n;
    return (x < 0) ? -mag : mag;
  endfunction

  // Advance the block state by one sample; return 1 with the level on block end
  function automatic bit level_of_sample(input logic [15:0] smp, input logic lst,
                                         output level_t res);
    logic [SumW:0] acc;
    longint        l;
    longint        d;
    longint        lv;
    acc = '0;
    res = '{level: '0, silent: 1'b0};
    if (blk_cnt < MaxBlockLen) begin
      blk_cnt = blk_cnt + 1'b1;
      acc = {1'b0, blk_sum} +
            (SumW+1)'(longint'($signed(smp)) * longint'($signed(smp)));
      blk_sum = acc[SumW] ? SumMax : acc[SumW-1:0];
    end
    if (!lst) return 1'b0;
    if (blk_sum == '0 || blk_cnt == '0) begin
      res.level = FloorLevel;
      res.silent = 1'b1;
    end else begin
      l = log2_q24(64'(blk_sum)) - log2_q24(64'(blk_cnt)) - (longint'(30) << LogFrac);
      d = round_pow2(l * DbPerOct, LogFrac) + DbPerOct;
      lv = round_pow2(d, 16);
      if (lv < FloorLevel) lv = FloorLevel;
      if (lv > CeilLevel) lv = CeilLevel;
      res.level = LevelW'(lv);
    end
    blk_sum = '0;
    blk_cnt = '0;
    return 1'b1;
  endfunction

  // Drive one sample, wait for its transaction, record the expected level
  task automatic send_sample(input logic [15:0] smp, input logic lst,
                             input bit typed, input level_t typed_res);
    level_t res;
    if (!no_idle && $urandom_range(99) < 37) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tlast_i  <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (level_of_sample(smp, lst, res)) level_q = {level_q, (typed ? typed_res : res)};
  endtask

  // Random block: mostly short, with a varied amplitude profile
  task automatic send_block(input int len);
    int     kind;
    logic [15:0] smp;
    level_t none;
    none = '{level: '0, silent: 1'b0};
    kind = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: smp = '0;
        1: smp = 16'($signed($urandom_range(0, 6)) - 3);
        2: smp = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        3: smp = 16'($signed($urandom_range(0, 511)) - 256);
        default: smp = 16'($urandom);
      endcase
      send_sample(smp, i == len - 1, 1'b0, none);
    end
  endtask

  // Sink: random backpressure and check of every result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    level_t exp_res;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result level %0d silent %0b", $time,
                   $signed(m_axis_tdata_o[16:0]), m_axis_tuser_o);
          err_cnt++;
        end else begin
          exp_res = level_q.pop_front();
          if (m_axis_tdata_o[16:0] !== exp_res.level) begin
            $display("%0t: level_db expected %0d actual %0d", $time, exp_res.level,
                     $signed(m_axis_tdata_o[16:0]));
            err_cnt++;
          end
          if (m_axis_tuser_o !== exp_res.silent) begin
            $display("%0t: silent expected %0b actual %0b", $time, exp_res.silent,
                     m_axis_tuser_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Hold a hard limit on run length
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("rms_level_db_meter_top test failed");
      $finish;
    end
  end

  initial begin
    level_t want;
    int     n_items;

    // Directed table: typed levels only for silent blocks and a single 0x8000 sample
    rows = '{
      '{16'h0000, 1'b1, 1'b1, FloorLevel, 1'b1},
      '{16'h8000, 1'b1, 1'b1, 17'sd771, 1'b0},
      '{16'h7FFF, 1'b1, 1'b0, '0, 1'b0},
      '{16'h0001, 1'b1, 1'b0, '0, 1'b0},
      '{16'hFFFF, 1'b1, 1'b0, '0, 1'b0},
      '{16'h0000, 1'b0, 1'b0, '0, 1'b0},
      '{16'h0000, 1'b0, 1'b0, '0, 1'b0},
      '{16'h0000, 1'b1, 1'b1, FloorLevel, 1'b1},
      '{16'h5555, 1'b0, 1'b0, '0, 1'b0},
      '{16'hAAAA, 1'b0, 1'b0, '0, 1'b0},
      '{16'h7FFF, 1'b0, 1'b0, '0, 1'b0},
      '{16'h8000, 1'b1, 1'b0, '0, 1'b0},
      '{16'h0000, 1'b0, 1'b0, '0, 1'b0},
      '{16'h0001, 1'b1, 1'b0, '0, 1'b0},
      '{16'h8000, 1'b0, 1'b0, '0, 1'b0},
      '{16'h8000, 1'b0, 1'b0, '0, 1'b0},
      '{16'h8000, 1'b1, 1'b0, '0, 1'b0},
      '{16'h1234, 1'b0, 1'b0, '0, 1'b0},
      '{16'hEDCB, 1'b1, 1'b0, '0, 1'b0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      want = '{level: rows[i].level, silent: rows[i].silent};
      send_sample(rows[i].smp, rows[i].lst, rows[i].typed, want);
    end

    // Random blocks, with one stretch free of idling on both sides
    n_items = 0;
    while (n_items < 1850) begin
      int len;
      no_idle = (n_items >= 600 && n_items < 900);
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      send_block(len);
      n_items += len;
    end
    no_idle = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("rms_level_db_meter_top test passed");
    end else begin
      $display("rms_level_db_meter_top test failed");
    end
    $finish;
  end

endmodule

// ===== rms_level_db_meter_top.f =====
src/rldm_pkg.sv
src/rldm_ctrl.sv
src/rldm_dp.sv
src/rms_level_db_meter_top.sv
tb/sv/rms_level_db_meter_top_tb.sv
